// ----- hdl/mu_group_admission_table_assert.svh -----
// Assertion macros shared by the MU group admission table RTL.
// No dependencies; included by the top level.
`ifndef MU_GROUP_ADMISSION_TABLE_ASSERT_SVH
`define MU_GROUP_ADMISSION_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MGAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mgat assertion failed (same cycle)");
// next-cycle implication
`define MGAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mgat assertion failed (next cycle)");
`else
`define MGAT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MGAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/mgat_pkg.sv -----
// Types, constants and helpers for the MU group admission table.
// No dependencies; imported by every module but the generic RAM.
package mgat_pkg;

    localparam int GROUP_COUNT     = 8;
    localparam int USERS_PER_GROUP = 8;

    localparam int GIDX_W   = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int IDX_W    = $clog2(USERS_PER_GROUP);
    localparam int CNT_W    = $clog2(USERS_PER_GROUP + 1);
    localparam int ADDR_W   = GIDX_W + IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    // worst case of all member stream counts in one group
    localparam int SUM_W    = $clog2(USERS_PER_GROUP * 255 + 1);

    localparam int CFG_IDX_W = 2;

    localparam logic [4:0] STREAM_CAP_LIMIT = 5'd16;
    localparam logic [4:0] UL_MIN_RANK      = 5'd2;

    localparam logic signed [7:0] RST_MIN_RSSI    = -8'sd82;
    localparam logic signed [7:0] RST_MIN_SNR     = 8'sd10;
    localparam logic [4:0]        RST_MAX_STREAMS = 5'd16;

    // group flag bits
    localparam int FL_DL  = 0;
    localparam int FL_UL  = 1;
    localparam int FL_ACT = 2;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SET    = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_EXISTS   = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_BUSY     = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RSSI    = 2'd0,
        CFG_MIN_SNR     = 2'd1,
        CFG_MAX_STREAMS = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_FINISH
    } t_state;

    // one member slot as held in the member RAM
    typedef struct packed {
        logic [7:0] id;
        logic [7:0] corr;
        logic [7:0] iso;
        logic [4:0] rank;
        logic [7:0] streams;
        logic       ready;
    } t_entry;

    typedef struct packed {
        logic             clear;
        logic             check;
        logic [IDX_W-1:0] idx;
    } t_scan_ctl;

    typedef struct packed {
        logic             found;
        logic             bad;
        logic [IDX_W-1:0] pos;
        t_entry           word;
        logic [SUM_W-1:0] sum;
    } t_scan_stat;

    function automatic logic [4:0] stream_cap(input logic [4:0] max_streams);
        return (max_streams > STREAM_CAP_LIMIT) ? STREAM_CAP_LIMIT : max_streams;
    endfunction

    function automatic logic [3:0] count4(input logic [CNT_W-1:0] c);
        logic [7:0] w;
        w = 8'(c);
        return w[3:0];
    endfunction

endpackage

// ----- hdl/mu_group_admission_table.sv -----
// MU-MIMO group admission table: top level, sequencer and group state.
// Depends on mgat_pkg, mgat_ram, mgat_scan and the assertion macro header.
//
// Usage:
//  Requests enter on the input channel (i_in_valid / o_in_stall) and carry
//  one operation on one group. Each request gives exactly one result on the
//  output channel (o_out_valid / i_out_stall).
//  Configuration registers are written through i_cfg_valid / o_cfg_ready;
//  the port is always ready. Write them only while no request is in flight.
//  Timing: a request walks the n members of its group through the member RAM
//  one slot per cycle, then decides; a remove then walks the slots above the
//  removed member again to move each one down for compaction. The next
//  request is taken only after the result is loaded into the output register.
//  Out-of-range groups skip the walk and go straight to the result.
//  The result sits in an output register: while it is stalled the block
//  accepts and processes the next request, holding only at the final load.
//  Reset clears all groups (empty, idle, not ready), loads the register
//  defaults and drops o_out_valid. The member RAM is not cleared; only slots
//  below a group's user count are ever read.
`include "mu_group_admission_table_assert.svh"

module mu_group_admission_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_operation,
    input  logic [7:0]                        i_group_index,
    input  logic [7:0]                        i_user_id,
    input  logic signed [7:0]                 i_rssi_dbm,
    input  logic signed [7:0]                 i_snr_db,
    input  logic [7:0]                        i_correlation,
    input  logic [7:0]                        i_isolation,
    input  logic [4:0]                        i_rank,
    input  logic [7:0]                        i_stream_request,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_status,
    output logic [3:0]                        o_user_count,
    output logic [4:0]                        o_stream_total,
    output logic                              o_downlink_ready,
    output logic                              o_uplink_ready,
    output logic                              o_group_active,
    output logic                              o_user_ready,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mgat_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);
    import mgat_pkg::*;

    // state machine
    t_state r_state, n_state;

    // captured request
    logic [2:0]        r_op;
    logic              r_gidx_bad;
    logic [GIDX_W-1:0] r_gidx;
    logic [7:0]        r_uid;
    logic signed [7:0] r_rssi;
    logic signed [7:0] r_snr;
    logic [7:0]        r_corr;
    logic [7:0]        r_iso;
    logic [4:0]        r_rank;
    logic [7:0]        r_req;

    // configuration
    logic signed [7:0] r_min_rssi;
    logic signed [7:0] r_min_snr;
    logic [4:0]        r_max_streams;
    logic [4:0]        cap;

    // group state
    logic [CNT_W-1:0]  r_grp_users   [GROUP_COUNT];
    logic [4:0]        r_grp_streams [GROUP_COUNT];
    logic [2:0]        r_grp_flags   [GROUP_COUNT];
    logic [CNT_W-1:0]  cur_users;
    logic [4:0]        cur_streams;
    logic [2:0]        cur_flags;

    // slot walk
    logic [CNT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_shift_end;
    logic              r_chk_vld;
    logic [IDX_W-1:0]  r_chk_idx;

    // per-request result
    t_status           r_res_status;
    logic              r_res_ready;

    // output register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [3:0]        r_out_count;
    logic [4:0]        r_out_streams;
    logic [2:0]        r_out_flags;
    logic              r_out_ready;

    // FSM outputs
    logic              c_accept;
    logic              c_issue;
    logic              c_decide;
    logic              c_shift;
    logic              c_load;

    // decision logic
    t_status           d_status;
    logic              d_ready;
    logic              d_wr;
    logic [IDX_W-1:0]  d_wr_pos;
    t_entry            d_wr_word;
    logic              d_upd;
    logic [CNT_W-1:0]  d_users;
    logic [4:0]        d_streams;
    logic [2:0]        d_flags;
    logic              d_shift;
    logic              found_ready;
    logic [5:0]        add_sum;
    logic [SUM_W-1:0]  set_total;

    // memory and scan unit
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    t_entry            ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    t_entry            ram_rd_data;
    t_scan_ctl         scan_ctl;
    t_scan_stat        scan_stat;

    assign cap         = stream_cap(r_max_streams);
    assign cur_users   = r_grp_users[r_gidx];
    assign cur_streams = r_grp_streams[r_gidx];
    assign cur_flags   = r_grp_flags[r_gidx];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------- FSM
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_state = (i_group_index >= 8'(GROUP_COUNT)) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!c_issue) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = d_shift ? S_SHIFT : S_FINISH;
            end
            S_SHIFT: begin
                if (!c_issue) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (c_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        c_accept = 1'b0;
        c_issue  = 1'b0;
        c_decide = 1'b0;
        c_shift  = 1'b0;
        c_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                c_accept = i_in_valid;
            end
            S_SCAN: begin
                c_issue = (r_rd_idx < cur_users);
            end
            S_DECIDE: begin
                c_decide = 1'b1;
            end
            S_SHIFT: begin
                c_issue = (r_rd_idx < r_shift_end);
                c_shift = r_chk_vld;
            end
            S_FINISH: begin
                c_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                c_accept = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------- request capture
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_op       <= i_operation;
            r_gidx_bad <= (i_group_index >= 8'(GROUP_COUNT));
            r_gidx     <= i_group_index[GIDX_W-1:0];
            r_uid      <= i_user_id;
            r_rssi     <= i_rssi_dbm;
            r_snr      <= i_snr_db;
            r_corr     <= i_correlation;
            r_iso      <= i_isolation;
            r_rank     <= i_rank;
            r_req      <= i_stream_request;
        end
    end

    // ---------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rssi    <= RST_MIN_RSSI;
            r_min_snr     <= RST_MIN_SNR;
            r_max_streams <= RST_MAX_STREAMS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_RSSI: begin
                    r_min_rssi <= i_cfg_data;
                end
                CFG_MIN_SNR: begin
                    r_min_snr <= i_cfg_data;
                end
                CFG_MAX_STREAMS: begin
                    r_max_streams <= i_cfg_data[4:0];
                end
                default: begin
                    r_max_streams <= r_max_streams;
                end
            endcase
        end
    end

    // -------------------------------------------------------------- slot walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= c_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_rd_idx <= '0;
        end else if (c_issue) begin
            r_rd_idx <= r_rd_idx + CNT_W'(1);
        end else if (c_decide && d_shift) begin
            r_rd_idx <= CNT_W'(scan_stat.pos) + CNT_W'(1);
        end
        if (c_decide && d_shift) begin
            r_shift_end <= cur_users;
        end
        r_chk_idx <= r_rd_idx[IDX_W-1:0];
    end

    assign ram_rd_addr = {r_gidx, r_rd_idx[IDX_W-1:0]};

    assign scan_ctl.clear = c_accept;
    assign scan_ctl.check = r_chk_vld && (r_state == S_SCAN);
    assign scan_ctl.idx   = r_chk_idx;

    mgat_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_entry       (ram_rd_data),
        .i_user_id     (r_uid),
        .i_correlation (r_corr),
        .i_isolation   (r_iso),
        .o_stat        (scan_stat)
    );

    // ---------------------------------------------------------------- decide
    assign found_ready = scan_stat.found & scan_stat.word.ready;
    assign add_sum     = {1'b0, cur_streams} + {1'b0, r_rank};
    assign set_total   = scan_stat.sum + SUM_W'(r_req);

    always_comb begin
        d_status  = ST_INVALID;
        d_ready   = found_ready;
        d_wr      = 1'b0;
        d_wr_pos  = scan_stat.pos;
        d_wr_word = scan_stat.word;
        d_upd     = 1'b0;
        d_users   = cur_users;
        d_streams = cur_streams;
        d_flags   = cur_flags;
        d_shift   = 1'b0;
        case (r_op)
            OP_ADD: begin
                if (scan_stat.found) begin
                    d_status = ST_EXISTS;
                end else if (cur_users >= CNT_W'(USERS_PER_GROUP)) begin
                    d_status = ST_NOSPACE;
                end else if (r_rssi < r_min_rssi || r_snr < r_min_snr) begin
                    d_status = ST_INVALID;
                end else if (scan_stat.bad) begin
                    d_status = ST_INVALID;
                end else if (add_sum > {1'b0, cap}) begin
                    d_status = ST_NOSPACE;
                end else begin
                    d_status          = ST_OK;
                    d_ready           = 1'b0;
                    d_wr              = 1'b1;
                    d_wr_pos          = cur_users[IDX_W-1:0];
                    d_wr_word.id      = r_uid;
                    d_wr_word.corr    = r_corr;
                    d_wr_word.iso     = r_iso;
                    d_wr_word.rank    = r_rank;
                    d_wr_word.streams = '0;
                    d_wr_word.ready   = 1'b0;
                    d_upd             = 1'b1;
                    d_users           = cur_users + CNT_W'(1);
                    d_streams         = add_sum[4:0];
                    if (cur_users >= CNT_W'(1)) begin
                        d_flags[FL_DL] = 1'b1;
                        if (r_rank >= UL_MIN_RANK) begin
                            d_flags[FL_UL] = 1'b1;
                        end
                    end
                end
            end
            OP_REMOVE: begin
                d_ready = 1'b0;
                if (!scan_stat.found) begin
                    d_status = ST_NOTFOUND;
                end else begin
                    d_status  = ST_OK;
                    d_upd     = 1'b1;
                    d_shift   = 1'b1;
                    d_users   = cur_users - CNT_W'(1);
                    d_streams = (cur_streams >= scan_stat.word.rank) ?
                                cur_streams - scan_stat.word.rank : 5'd0;
                    if (cur_users <= CNT_W'(2)) begin
                        d_flags[FL_DL] = 1'b0;
                        d_flags[FL_UL] = 1'b0;
                    end
                end
            end
            OP_SET: begin
                if (r_req > 8'(cap)) begin
                    d_status = ST_INVALID;
                end else if (!scan_stat.found) begin
                    d_status = ST_NOTFOUND;
                end else begin
                    // count is stored even when the group total overflows
                    d_wr              = 1'b1;
                    d_wr_word.streams = r_req;
                    if (set_total <= SUM_W'(cap)) begin
                        d_status        = ST_OK;
                        d_wr_word.ready = 1'b1;
                        d_ready         = 1'b1;
                    end else begin
                        d_status = ST_NOSPACE;
                    end
                end
            end
            OP_START: begin
                if (cur_flags[FL_ACT]) begin
                    d_status = ST_BUSY;
                end else if (cur_users == '0) begin
                    d_status = ST_INVALID;
                end else begin
                    d_status        = ST_OK;
                    d_upd           = 1'b1;
                    d_flags[FL_ACT] = 1'b1;
                end
            end
            OP_STOP: begin
                d_status        = ST_OK;
                d_upd           = 1'b1;
                d_flags[FL_ACT] = 1'b0;
            end
            default: begin
                d_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_decide) begin
            r_res_status <= d_status;
            r_res_ready  <= d_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
                r_grp_users[g]   <= '0;
                r_grp_streams[g] <= '0;
                r_grp_flags[g]   <= '0;
            end
        end else if (c_decide && d_upd) begin
            r_grp_users[r_gidx]   <= d_users;
            r_grp_streams[r_gidx] <= d_streams;
            r_grp_flags[r_gidx]   <= d_flags;
        end
    end

    // ---------------------------------------------------------- member RAM
    // compaction writes slot j-1 while slot j+1 is being read
    always_comb begin
        if (c_shift) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {r_gidx, r_chk_idx - IDX_W'(1)};
            ram_wr_data = ram_rd_data;
        end else begin
            ram_wr_en   = c_decide && d_wr;
            ram_wr_addr = {r_gidx, d_wr_pos};
            ram_wr_data = d_wr_word;
        end
    end

    mgat_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MEM_DEPTH)
    ) u_member_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (c_issue),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // -------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            if (r_gidx_bad) begin
                r_out_status  <= ST_INVALID;
                r_out_count   <= '0;
                r_out_streams <= '0;
                r_out_flags   <= '0;
                r_out_ready   <= 1'b0;
            end else begin
                r_out_status  <= r_res_status;
                r_out_count   <= count4(cur_users);
                r_out_streams <= cur_streams;
                r_out_flags   <= cur_flags;
                r_out_ready   <= r_res_ready;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_user_count     = r_out_count;
    assign o_stream_total   = r_out_streams;
    assign o_downlink_ready = r_out_flags[FL_DL];
    assign o_uplink_ready   = r_out_flags[FL_UL];
    assign o_group_active   = r_out_flags[FL_ACT];
    assign o_user_ready     = r_out_ready;

    // ------------------------------------------------------------- assertions
    `MGAT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `MGAT_ASSERT_NEXT(a_no_repeat, i_clk, i_rst_n, o_out_valid && !i_out_stall && r_state != S_FINISH, !o_out_valid)
    `MGAT_ASSERT_IMPL(a_stream_cap, i_clk, i_rst_n, o_out_valid, o_stream_total <= STREAM_CAP_LIMIT)
    `MGAT_ASSERT_IMPL(a_ul_needs_dl, i_clk, i_rst_n, o_out_valid && o_uplink_ready, o_downlink_ready)

endmodule

// ----- hdl/mgat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mgat_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/mgat_scan.sv -----
// Shared compare/accumulate unit applied to one member slot per cycle.
// Depends on mgat_pkg.
module mgat_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mgat_pkg::t_scan_ctl   i_ctl,
    input  mgat_pkg::t_entry      i_entry,
    input  logic [7:0]            i_user_id,
    input  logic [7:0]            i_correlation,
    input  logic [7:0]            i_isolation,
    output mgat_pkg::t_scan_stat  o_stat
);
    import mgat_pkg::*;

    logic             r_found;
    logic             r_bad;
    logic [IDX_W-1:0] r_pos;
    t_entry           r_word;
    logic [SUM_W-1:0] r_sum;

    logic             match;
    logic             viol;

    assign match = (i_entry.id == i_user_id);
    // new user must not be more correlated or less isolated than any member
    assign viol  = (i_correlation > i_entry.corr) || (i_isolation < i_entry.iso);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_ctl.check) begin
            if (match) begin
                r_found <= 1'b1;
            end
            if (viol) begin
                r_bad <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.check) begin
            // the addressed user's own count is replaced by the request later
            r_sum <= r_sum + (match ? SUM_W'(0) : SUM_W'(i_entry.streams));
            if (match) begin
                r_pos  <= i_ctl.idx;
                r_word <= i_entry;
            end
        end
    end

    assign o_stat.found = r_found;
    assign o_stat.bad   = r_bad;
    assign o_stat.pos   = r_pos;
    assign o_stat.word  = r_word;
    assign o_stat.sum   = r_sum;

endmodule
